// ===== rtl/core/cod_pkg.sv =====
// Shared types and constants of the R squared evaluator.
// Used by every module under rtl/core except cod_ram; depends on nothing.
package cod_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_TERMS   = 6;

    localparam int DATA_W  = 32;                         // Q16.16 sample and coefficient
    localparam int FRAC_W  = 16;                         // fraction bits
    localparam int TERM_W  = 3;                          // term_count register
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);        // sample store address
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);    // sample count
    localparam int MUL_W   = DATA_W + 1;                 // multiplier operand
    localparam int PROD_W  = 2 * MUL_W;                  // registered product
    localparam int SCL_W   = PROD_W - FRAC_W;            // rescaled product
    localparam int ACC_W   = SCL_W;                      // model value accumulator
    localparam int YT_W    = DATA_W + CNT_W;             // running sum of y
    localparam int SUM_W   = 64;                         // sums of squares
    localparam int SQR_W   = 2 * DATA_W - FRAC_W + 1;    // one rescaled square
    localparam int QBITS   = FRAC_W + 1;                 // ratio fraction bits before rounding
    localparam int DIVN_W  = SUM_W + QBITS;              // divider dividend
    localparam int DIVD_W  = SUM_W;                      // divider divisor
    localparam int DCNT_W  = $clog2(DIVN_W + 1);         // divider step counter
    localparam int RQ_W    = DATA_W + 1;                 // rounded ratio
    localparam int R_W     = DATA_W + 2;                 // 1 - ratio before clipping
    localparam int PADDR_W = 5;                          // APB byte address

    localparam logic [DATA_W-1:0] ONE_Q16   = DATA_W'(1 << FRAC_W);
    localparam logic [SUM_W-1:0]  IP_LIMIT  = SUM_W'(32769);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    // register indexes (word address)
    localparam logic [TERM_W-1:0] REG_TERM_COUNT = 3'd0;
    localparam logic [TERM_W-1:0] REG_COEF_FIRST = 3'd1;
    localparam logic [TERM_W-1:0] REG_COEF_LAST  = 3'd6;
    localparam logic [TERM_W-1:0] TERM_RESET     = 3'd2;

    typedef logic [MAX_TERMS-1:0][DATA_W-1:0] t_coefs;

    typedef enum logic [4:0] {
        S_IDLE, S_PX, S_P, S_CP, S_ADD, S_RDIFF, S_RSQ, S_RACC,
        S_MEAN, S_MEANW, S_WRD, S_WDIFF, S_WSQ, S_WACC, S_WEND, S_RATIO, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL_PX, OP_SET_P, OP_MUL_CP, OP_ADD_TERM,
        OP_DIFF_RES, OP_SQ, OP_ADD_RES, OP_MEAN_START, OP_MEAN_SET,
        OP_DIFF_TOT, OP_ADD_TOT, OP_RATIO_START, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TERM_W-1:0] coef_sel;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic             last;
        logic             sstot_zero;
        logic             div_done;
        logic [CNT_W-1:0] count;
    } t_status;

endpackage

// ===== rtl/core/cod_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module cod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cod_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cod_pkg for widths.
module cod_div import cod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_dividend,
    input  logic [DIVD_W-1:0] i_divisor,
    output logic [DIVN_W-1:0] o_quotient,
    output logic              o_done
);

    logic [DCNT_W-1:0] r_steps;
    logic              r_busy;
    logic              r_done;
    logic [DIVN_W-1:0] r_quo;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_den;
    logic [DIVD_W:0]   w_trial;
    logic              w_fits;

    // shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_quo[DIVN_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_den};

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= DCNT_W'(DIVN_W);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVN_W-2:0], w_fits};
            r_rem <= w_fits ? DIVD_W'(w_trial - {1'b0, r_den}) : DIVD_W'(w_trial);
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/core/cod_dp.sv =====
// Datapath: sample store, shared multiplier, sums, mean and ratio.
// Depends on cod_pkg, cod_ram and cod_div.
module cod_dp import cod_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [TERM_W-1:0]        i_term_count,
    input  t_coefs                   i_coefs,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    input  logic                     i_last_sample,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_r_squared,
    output logic                     o_zero_spread,
    output logic                     o_saturated,
    output logic [CNT_W-1:0]         o_sample_count
);

    // clip flag in the top bit, clamped value below
    function automatic logic [DATA_W:0] sat32(input logic signed [SCL_W-1:0] v);
        logic [SCL_W-DATA_W:0] hi;
        hi = v[SCL_W-1:DATA_W-1];
        if (hi == '0 || hi == '1) begin
            return {1'b0, v[DATA_W-1:0]};
        end else if (v[SCL_W-1]) begin
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic signed [DATA_W-1:0] r_x, r_y, r_p, r_mean;
    logic                     r_last;
    logic [CNT_W-1:0]         r_count;
    logic signed [YT_W-1:0]   r_ytot;
    logic [SUM_W-1:0]         r_res, r_sstot;
    logic                     r_clip;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MUL_W-1:0]  r_d;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_out_r2;
    logic                     r_out_zero, r_out_sat;
    logic [CNT_W-1:0]         r_out_cnt;

    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_round;
    logic signed [SCL_W-1:0]  w_scaled;
    logic [DATA_W:0]          w_p_sat, w_f_sat;
    logic [SQR_W-1:0]         w_sq;
    logic [SUM_W-1:0]         w_base, w_sat_sum;
    logic [SUM_W:0]           w_sum;
    logic [YT_W-1:0]          w_ymag;
    logic [DIVN_W-1:0]        w_dividend, w_quo;
    logic [DIVD_W-1:0]        w_divisor;
    logic                     w_div_done;
    logic [DATA_W-1:0]        w_ram_q, w_qlo;
    logic                     w_ip_big, w_r_clip;
    logic [RQ_W-1:0]          w_q;
    logic signed [R_W-1:0]    w_r;
    logic [R_W-DATA_W:0]      w_r_hi;

    // operand select for the shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_PX: begin
                w_mul_a = MUL_W'(r_p);
                w_mul_b = MUL_W'(r_x);
            end
            OP_MUL_CP: begin
                w_mul_a = MUL_W'($signed(i_coefs[i_cmd.coef_sel]));
                w_mul_b = MUL_W'(r_p);
            end
            default: begin
                w_mul_a = r_d;
                w_mul_b = r_d;
            end
        endcase
    end

    // rescale by 2^16, rounding half up
    assign w_round  = r_prod + $signed(ROUND_HALF);
    assign w_scaled = SCL_W'(w_round >>> FRAC_W);
    assign w_p_sat  = sat32(w_scaled);
    assign w_f_sat  = sat32(r_acc);

    // rounded square and saturating sum
    assign w_sq      = SQR_W'(r_prod[2*DATA_W-1:FRAC_W]) + SQR_W'(r_prod[FRAC_W-1]);
    assign w_base    = (i_cmd.op == OP_ADD_RES) ? r_res : r_sstot;
    assign w_sum     = {1'b0, w_base} + (SUM_W+1)'(w_sq);
    assign w_sat_sum = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];

    // divider operands: mean of y, or the residual ratio
    assign w_ymag     = r_ytot[YT_W-1] ? YT_W'(-r_ytot) : YT_W'(r_ytot);
    assign w_dividend = (i_cmd.op == OP_RATIO_START) ? {r_res, {QBITS{1'b0}}}
                                                     : DIVN_W'(w_ymag) + DIVN_W'(r_count >> 1);
    assign w_divisor  = (i_cmd.op == OP_RATIO_START) ? r_sstot : DIVD_W'(r_count);
    assign w_qlo      = w_quo[DATA_W-1:0];

    // 1 - ratio, rounded to 16 fraction bits and clipped below
    assign w_ip_big = w_quo[DIVN_W-1:QBITS] > IP_LIMIT;
    assign w_q      = RQ_W'(w_quo[DATA_W:1]) + RQ_W'(w_quo[0]);
    assign w_r      = R_W'(ONE_Q16) - R_W'(w_q);
    assign w_r_hi   = w_r[R_W-1:DATA_W-1];
    assign w_r_clip = w_ip_big || !(w_r_hi == '0 || w_r_hi == '1);

    cod_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_MEAN_START || i_cmd.op == OP_RATIO_START),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    cod_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_y_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_ram_q)
    );

    // per data set totals and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ytot  <= '0;
            r_res   <= '0;
            r_count <= '0;
            r_clip  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_ytot  <= r_ytot + YT_W'(i_y_value);
                    r_count <= r_count + 1'b1;
                end
                OP_SET_P:    r_clip <= r_clip | w_p_sat[DATA_W];
                OP_DIFF_RES: r_clip <= r_clip | w_f_sat[DATA_W];
                OP_ADD_RES: begin
                    r_res  <= w_sat_sum;
                    r_clip <= r_clip | w_sum[SUM_W];
                end
                OP_ADD_TOT:  r_clip <= r_clip | w_sum[SUM_W];
                OP_RESULT: begin
                    r_ytot  <= '0;
                    r_res   <= '0;
                    r_count <= '0;
                    r_clip  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_x_value;
                r_y    <= i_y_value;
                r_last <= i_last_sample;
                r_p    <= $signed(ONE_Q16);
                r_acc  <= (i_term_count != '0) ? ACC_W'($signed(i_coefs[0])) : '0;
            end
            OP_MUL_PX, OP_MUL_CP, OP_SQ: r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
            OP_SET_P:    r_p   <= $signed(w_p_sat[DATA_W-1:0]);
            OP_ADD_TERM: r_acc <= r_acc + w_scaled;
            OP_DIFF_RES: r_d   <= MUL_W'(r_y) - MUL_W'($signed(w_f_sat[DATA_W-1:0]));
            OP_MEAN_SET: begin
                r_mean  <= r_ytot[YT_W-1] ? $signed(-w_qlo) : $signed(w_qlo);
                r_sstot <= '0;
            end
            OP_DIFF_TOT: r_d     <= MUL_W'($signed(w_ram_q)) - MUL_W'(r_mean);
            OP_ADD_TOT:  r_sstot <= w_sat_sum;
            OP_RESULT: begin
                r_out_cnt <= r_count;
                if (r_sstot == '0) begin
                    r_out_r2   <= '0;
                    r_out_zero <= 1'b1;
                    r_out_sat  <= r_clip;
                end else begin
                    r_out_r2   <= w_r_clip ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                                           : $signed(w_r[DATA_W-1:0]);
                    r_out_zero <= 1'b0;
                    r_out_sat  <= r_clip | w_r_clip;
                end
            end
            default: ;
        endcase
    end

    assign o_status.last       = r_last || (r_count == CNT_W'(MAX_SAMPLES));
    assign o_status.sstot_zero = (r_sstot == '0);
    assign o_status.div_done   = w_div_done;
    assign o_status.count      = r_count;

    assign o_r_squared    = r_out_r2;
    assign o_zero_spread  = r_out_zero;
    assign o_saturated    = r_out_sat;
    assign o_sample_count = r_out_cnt;

endmodule

// ===== rtl/core/cod_ctrl.sv =====
// Controller: sequences loading, the mean, the sum of squares walk and the ratio.
// Depends on cod_pkg.
module cod_ctrl import cod_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [TERM_W-1:0] i_term_count,
    input  t_status           i_status,
    output t_cmd              o_cmd
);

    t_state            r_state, n_state;
    logic [TERM_W-1:0] r_term, n_term;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [TERM_W-1:0] w_terms;
    logic              w_out_free;

    assign w_terms    = (i_term_count > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : i_term_count;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_term         = r_term;
        n_idx          = r_idx;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd.op       = OP_NONE;
        o_cmd.coef_sel = r_term;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_addr  = r_idx[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_term   = TERM_W'(1);
                    n_state  = (w_terms > TERM_W'(1)) ? S_PX : S_RDIFF;
                end
            end
            S_PX: begin
                o_cmd.op = OP_MUL_PX;
                n_state  = S_P;
            end
            S_P: begin
                o_cmd.op = OP_SET_P;
                n_state  = S_CP;
            end
            S_CP: begin
                o_cmd.op = OP_MUL_CP;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = OP_ADD_TERM;
                n_term   = r_term + 1'b1;
                n_state  = (r_term + 1'b1 == w_terms) ? S_RDIFF : S_PX;
            end
            S_RDIFF: begin
                o_cmd.op = OP_DIFF_RES;
                n_state  = S_RSQ;
            end
            S_RSQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_RACC;
            end
            S_RACC: begin
                o_cmd.op = OP_ADD_RES;
                n_state  = i_status.last ? S_MEAN : S_IDLE;
            end
            S_MEAN: begin
                o_cmd.op = OP_MEAN_START;
                n_state  = S_MEANW;
            end
            S_MEANW: begin
                if (i_status.div_done) begin
                    o_cmd.op = OP_MEAN_SET;
                    n_idx    = '0;
                    n_state  = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_WDIFF;
            end
            S_WDIFF: begin
                o_cmd.op = OP_DIFF_TOT;
                n_state  = S_WSQ;
            end
            S_WSQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_WACC;
            end
            S_WACC: begin
                o_cmd.op = OP_ADD_TOT;
                n_idx    = r_idx + 1'b1;
                n_state  = (r_idx + 1'b1 == i_status.count) ? S_WEND : S_WRD;
            end
            S_WEND: begin
                if (i_status.sstot_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_RATIO_START;
                    n_state  = S_RATIO;
                end
            end
            S_RATIO: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_RESULT) |-> !(r_out_valid && i_out_stall))
        else $error("result written over a pending item");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_MEANW || r_state == S_RATIO))
        else $error("divider finished outside a wait state");

    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRD) |-> (r_idx < i_status.count))
        else $error("walk index past sample count");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

endmodule

// ===== rtl/core/coefficient_of_determination.sv =====
// Each accepted item is one (x, y) sample; the input stalls while a sample is
// worked on, and the work grows with the number of polynomial terms in use
// (clamped to 6; no terms costs the same as one), all products coming from one
// shared 33x33 multiplier. The last sample of a set (or the 1024th) adds the
// closing work: a bit-serial division of 81 steps forms the mean, a walk reads
// each stored y from the sample RAM and sums its squared distance to the mean,
// and a second division of the same length forms the ratio. A set with zero
// spread skips the ratio. A finished result waits in an output register while
// the next set loads; a second finished set stalls there.
// Depends on cod_pkg, cod_ctrl and cod_dp.
module coefficient_of_determination import cod_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_y_value,
    input  logic                     i_last_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_r_squared,
    output logic                     o_zero_spread,
    output logic                     o_saturated,
    output logic [CNT_W-1:0]         o_sample_count,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    logic [TERM_W-1:0] r_term_count;
    t_coefs            r_coefs;
    logic [TERM_W-1:0] w_idx;
    logic [TERM_W-1:0] w_coef_idx;
    logic              w_is_coef;
    t_cmd              w_cmd;
    t_status           w_status;

    assign w_idx      = paddr[PADDR_W-1:2];
    assign w_is_coef  = (w_idx >= REG_COEF_FIRST) && (w_idx <= REG_COEF_LAST);
    assign w_coef_idx = w_idx - REG_COEF_FIRST;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_RESET;
            r_coefs      <= '0;
        end else if (psel && penable && pwrite) begin
            if (w_idx == REG_TERM_COUNT) begin
                r_term_count <= pwdata[TERM_W-1:0];
            end else if (w_is_coef) begin
                r_coefs[w_coef_idx] <= pwdata;
            end
        end
    end

    // register read back
    always_comb begin
        if (w_idx == REG_TERM_COUNT) begin
            prdata = DATA_W'(r_term_count);
        end else if (w_is_coef) begin
            prdata = r_coefs[w_coef_idx];
        end else begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    cod_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_term_count (r_term_count),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    cod_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_term_count   (r_term_count),
        .i_coefs        (r_coefs),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_last_sample  (i_last_sample),
        .o_status       (w_status),
        .o_r_squared    (o_r_squared),
        .o_zero_spread  (o_zero_spread),
        .o_saturated    (o_saturated),
        .o_sample_count (o_sample_count)
    );

endmodule

// ===== tb/sv/coefficient_of_determination_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the R squared evaluator: sample sets in, one result per set out.
// Depends on cod_pkg and the coefficient_of_determination top level only.
module coefficient_of_determination_tb;
    import cod_pkg::*;

    localparam int    QUIET_LIMIT = 30000;
    localparam int    STORE_DEPTH = 1024;
    localparam int    LONG_HOLD   = 400;
    localparam longint I32_MAX    = 64'sd2147483647;
    localparam longint I32_MIN    = -64'sd2147483648;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(28);

    typedef struct packed {
        logic signed [DATA_W-1:0] r2;
        logic                     flat;
        logic                     clip;
        logic [CNT_W-1:0]         n;
    } t_r2;

    typedef struct {
        longint x;
        longint y;
        bit     last;
        bit     typed;
        t_r2    want;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_x_value = '0;
    logic signed [DATA_W-1:0] i_y_value = '0;
    logic                     i_last_sample = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_r_squared;
    logic                     o_zero_spread;
    logic                     o_saturated;
    logic [CNT_W-1:0]         o_sample_count;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    coefficient_of_determination dut (.*);

    always #6 i_clk = ~i_clk;

    // fit model copy: configuration and per-set accumulators
    int unsigned fit_terms = TERM_RESET;
    longint      fit_coef [MAX_TERMS];
    longint      y_mem [STORE_DEPTH];
    longint      y_sum;
    logic [63:0] res_sum;
    int          set_count;
    bit          set_clipped;

    t_r2 r2_pending [$];
    int  mismatches;
    bit  hold_req;
    int  quiet_cycles;

    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > I32_MAX) begin
            set_clipped = 1'b1;
            return I32_MAX;
        end
        if (v < I32_MIN) begin
            set_clipped = 1'b1;
            return I32_MIN;
        end
        return v;
    endfunction

    function automatic logic [63:0] sq16(longint d);
        logic [63:0]  m;
        logic [127:0] s;
        m = (d < 0) ? 64'(-d) : 64'(d);
        s = 128'(m) * 128'(m);
        return s[79:16] + 64'(s[15]);
    endfunction

    function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
        if (a > ~b) begin
            set_clipped = 1'b1;
            return '1;
        end
        return a + b;
    endfunction

    function automatic longint fit_value(longint x);
        int     n;
        longint p;
        longint acc;
        n = (fit_terms > MAX_TERMS) ? MAX_TERMS : fit_terms;
        p = 64'sd65536;
        acc = 0;
        for (int j = 0; j < n; j++) begin
            if (j > 0) p = clamp32(rnd16(p * x));
            acc += rnd16(fit_coef[j] * p);
        end
        return clamp32(acc);
    endfunction

    // 1 - num/den in Q16.16, 17 quotient bits rounded half up
    function automatic longint one_minus_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] frac;
        longint      q;
        longint      r;
        ip = num / den;
        rem = num % den;
        frac = 0;
        if (ip > 64'd32769) begin
            set_clipped = 1'b1;
            return I32_MIN;
        end
        for (int i = 0; i < 17; i++) begin
            frac = frac << 1;
            if (rem >= den - rem) begin
                frac = frac | 64'd1;
                rem = rem - (den - rem);
            end else begin
                rem = rem << 1;
            end
        end
        q = longint'((ip << 16) + (frac >> 1) + (frac & 64'd1));
        r = 64'sd65536 - q;
        if (r < I32_MIN) begin
            set_clipped = 1'b1;
            r = I32_MIN;
        end
        return r;
    endfunction

    // advance the model by one sample; report the set result when it closes
    task automatic predict_sample(input longint x, input longint y, input bit last,
                                  output bit done, output t_r2 res);
        longint      mean;
        logic [63:0] sstot;
        longint      n;
        if (set_count < STORE_DEPTH) y_mem[set_count] = y;
        y_sum += y;
        res_sum = sum_sat(res_sum, sq16(y - fit_value(x)));
        set_count++;
        done = last || set_count >= STORE_DEPTH;
        res = '0;
        if (!done) return;
        n = set_count;
        if (y_sum >= 0) mean = (y_sum + n / 2) / n;
        else mean = -((-y_sum + n / 2) / n);
        sstot = 0;
        for (int i = 0; i < n; i++) sstot = sum_sat(sstot, sq16(y_mem[i] - mean));
        if (sstot == 0) begin
            res.flat = 1'b1;
            res.r2 = '0;
        end else begin
            res.r2 = DATA_W'(one_minus_ratio(res_sum, sstot));
        end
        res.clip = set_clipped;
        res.n = CNT_W'(n);
        y_sum = 0;
        res_sum = 0;
        set_count = 0;
        set_clipped = 1'b0;
    endtask

    // write one register over the APB port, starting at a falling edge
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == 0) fit_terms = value[2:0];
        else if (addr / 4 <= MAX_TERMS) fit_coef[addr / 4 - 1] = longint'(signed'(value));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // offer one item at a falling edge, hold it until taken, leave at the next falling edge
    task automatic send_sample(input longint x, input longint y, input bit last,
                               input bit typed, input t_r2 want, input bit gaps);
        bit  done;
        t_r2 res;
        int  gap;
        i_in_valid = 1'b1;
        i_x_value = DATA_W'(x);
        i_y_value = DATA_W'(y);
        i_last_sample = last;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(x, y, last, done, res);
        if (typed) res = want;
        if (done) r2_pending.push_back(res);
        @(negedge i_clk);
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // drain every result, then let the block settle before touching registers
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (r2_pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic longint draw_value(int mode);
        case (mode)
            0: return longint'(signed'(DATA_W'($urandom_range(0, 1 << 20)) - (1 << 19)));
            1: return longint'(signed'(DATA_W'($urandom())));
            default: return ($urandom_range(0, 1) != 0) ? I32_MAX : I32_MIN;
        endcase
    endfunction

    function automatic longint draw_coef(int style);
        case (style)
            0: return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
            1: return I32_MAX;
            2: return I32_MIN;
            3: return 0;
            default: return longint'(signed'(DATA_W'($urandom())));
        endcase
    endfunction

    // one data set of random samples; y tracks a line in two of three small-value sets
    task automatic run_set(input int size, input bit close);
        int     mode;
        bit     gaps;
        bit     track;
        longint x;
        longint y;
        t_r2    none;
        none = '0;
        mode = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 3) != 0) ? 1 : 2);
        gaps = ($urandom_range(0, 3) != 0);
        track = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < size; i++) begin
            x = draw_value(mode);
            y = draw_value(mode);
            if (track && mode == 0)
                y = fit_coef[0] + ((fit_coef[1] * x) >>> 16)
                    + longint'($urandom_range(0, 4095)) - 2048;
            if (y > I32_MAX) y = I32_MAX;
            if (y < I32_MIN) y = I32_MIN;
            send_sample(x, y, close && (i == size - 1), 1'b0, none, gaps);
        end
    endtask

    // directed rows: extremes, single samples and a flat set have results known by eye
    t_row rows [$];
    function automatic t_row mk(longint x, longint y, bit last, bit typed,
                                logic signed [31:0] r2, bit flat, int n);
        t_row t;
        t.x = x;
        t.y = y;
        t.last = last;
        t.typed = typed;
        t.want = '{r2: r2, flat: flat, clip: 1'b0, n: CNT_W'(n)};
        return t;
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    default: i_out_stall = ($urandom_range(0, 19) == 0) ? 1'b1
                                         : (i_out_stall && $urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_r2 w;
        if (o_out_valid && !i_out_stall) begin
            if (r2_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result r2=%h", o_r_squared);
            end else begin
                w = r2_pending.pop_front();
                if (o_r_squared !== w.r2 || o_zero_spread !== w.flat
                    || o_saturated !== w.clip || o_sample_count !== w.n) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r2=%h flat=%b clip=%b n=%0d",
                                 w.r2, w.flat, w.clip, w.n,
                                 " got r2=%h flat=%b clip=%b n=%0d",
                                 o_r_squared, o_zero_spread, o_saturated, o_sample_count);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row t;
        foreach (fit_coef[j]) fit_coef[j] = 0;
        y_sum = 0;
        res_sum = 0;
        set_count = 0;
        set_clipped = 1'b0;
        mismatches = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under the reset configuration
        rows.push_back(mk(0, 0, 1, 1, 0, 1, 1));
        rows.push_back(mk(I32_MAX, I32_MIN, 1, 1, 0, 1, 1));
        rows.push_back(mk(I32_MIN, I32_MAX, 1, 1, 0, 1, 1));
        rows.push_back(mk(65536, 5 << 16, 0, 0, 0, 0, 0));
        rows.push_back(mk(131072, 5 << 16, 0, 0, 0, 0, 0));
        rows.push_back(mk(-65536, 5 << 16, 1, 1, 0, 1, 3));
        rows.push_back(mk(I32_MIN, I32_MIN, 0, 0, 0, 0, 0));
        rows.push_back(mk(I32_MAX, I32_MAX, 1, 0, 0, 0, 0));
        rows.push_back(mk(65536, 65536, 0, 0, 0, 0, 0));
        rows.push_back(mk(131072, 131072, 0, 0, 0, 0, 0));
        rows.push_back(mk(196608, 262144, 1, 0, 0, 0, 0));
        rows.push_back(mk(-1, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(32768, -32768, 1, 0, 0, 0, 0));
        foreach (rows[k]) begin
            t = rows[k];
            send_sample(t.x, t.y, t.last, t.typed, t.want, 1'b1);
        end
        wait_idle();

        // phases: term counts across the field, coefficients at the extremes
        for (int ph = 0; ph < 10; ph++) begin
            int style;
            automatic int terms [10] = '{1, 2, 0, 3, 6, 7, 1, 4, 5, 6};
            style = (ph == 3) ? 1 : (ph == 4) ? 2 : (ph == 5) ? 3 : (ph == 8) ? 4 : 0;
            reg_write(PADDR_W'(0), 32'(terms[ph]));
            for (int j = 0; j < MAX_TERMS; j++)
                reg_write(PADDR_W'(4 * (j + 1)), 32'(draw_coef(style)));
            reg_write(ADDR_UNUSED, $urandom());
            if (ph == 1) hold_req = 1'b1;
            if (ph == 6) begin
                run_set(STORE_DEPTH, 1'b0);
            end
            for (int m = 0; m < 72 / 8 * 8; m += 0) begin
                int size;
                size = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 50)
                     : ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                run_set(size, 1'b1);
                m += size;
            end
            wait_idle();
        end

        i_in_valid = 1'b0;
        while (r2_pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && r2_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cod_pkg.sv
rtl/core/cod_ram.sv
rtl/core/cod_div.sv
rtl/core/cod_dp.sv
rtl/core/cod_ctrl.sv
rtl/core/coefficient_of_determination.sv
tb/sv/coefficient_of_determination_tb.sv
